// File: sv/escape_run_length_decoder_defines.svh
// Assertion macros used by the escape run-length decoder checker.
`ifndef ESCAPE_RUN_LENGTH_DECODER_DEFINES_SVH
`define ESCAPE_RUN_LENGTH_DECODER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ERLD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ERLD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/erld_pkg.sv
// Types and constants of the escape run-length decoder.
`default_nettype none
package erld_pkg;

  // Decoder phases, one-hot.
  typedef enum logic [7:0] {
    PH_ID      = 8'b0000_0001,
    PH_PACK    = 8'b0000_0010,
    PH_SPECIAL = 8'b0000_0100,
    PH_CODE    = 8'b0000_1000,
    PH_IDCOUNT = 8'b0001_0000,
    PH_DATA    = 8'b0010_0000,
    PH_SPCOUNT = 8'b0100_0000,
    PH_FULL    = 8'b1000_0000
  } phase_t;

  // One stream byte held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } stage_t;

  // One run token.
  typedef struct packed {
    logic [7:0]  run_value;
    logic [8:0]  run_length;
    logic [14:0] run_start;
    logic        frame_done;
  } result_t;

endpackage
`default_nettype wire

// File: sv/erld_in_stage.sv
// Input register of the escape run-length decoder.
`default_nettype none
module erld_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            load,
  input  wire erld_pkg::stage_t in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output erld_pkg::stage_t     item
);
  import erld_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  stage_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the byte until the decoder consumes it.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule
`default_nettype wire

// File: sv/erld_decode.sv
// Header latch, phase machine and run clamping of the escape run-length decoder.
`default_nettype none
module erld_decode #(
  parameter int unsigned FRAME_BYTES = 32000
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire erld_pkg::stage_t item,
  input  wire logic             advance,
  output logic                  emit,
  output erld_pkg::result_t     result
);
  import erld_pkg::*;

  localparam logic [14:0] FRAME_LEFT = 15'(FRAME_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_code_r, id_code_nxt;
  logic [7:0]  pack_value_r, pack_value_nxt;
  logic [7:0]  special_code_r, special_code_nxt;
  logic [7:0]  held_data_r, held_data_nxt;
  logic [14:0] bytes_left_r, bytes_left_nxt;

  phase_t      eff_phase;
  logic [14:0] eff_left;
  logic [14:0] left_after;
  logic [8:0]  len_raw;
  logic [8:0]  len_clamped;
  logic [7:0]  value;
  logic        emit_raw;

  always_comb begin
    // A first byte restarts the picture before it is decoded.
    eff_phase        = item.first ? PH_ID : phase_r;
    eff_left         = item.first ? FRAME_LEFT : bytes_left_r;
    phase_nxt        = eff_phase;
    id_code_nxt      = id_code_r;
    pack_value_nxt   = pack_value_r;
    special_code_nxt = special_code_r;
    held_data_nxt    = held_data_r;
    emit_raw         = 1'b0;
    value            = item.data_byte;
    len_raw          = 9'd1;
    case (eff_phase)
      PH_ID: begin
        id_code_nxt = item.data_byte;
        phase_nxt   = PH_PACK;
      end
      PH_PACK: begin
        pack_value_nxt = item.data_byte;
        phase_nxt      = PH_SPECIAL;
      end
      PH_SPECIAL: begin
        special_code_nxt = item.data_byte;
        phase_nxt        = PH_CODE;
      end
      PH_CODE: begin
        // Id code wins over the special code.
        if (item.data_byte == id_code_r) begin
          phase_nxt = PH_IDCOUNT;
        end else if (item.data_byte == special_code_r) begin
          phase_nxt = PH_DATA;
        end else begin
          emit_raw = 1'b1;
        end
      end
      PH_IDCOUNT: begin
        emit_raw = 1'b1;
        value    = pack_value_r;
        len_raw  = {1'b0, item.data_byte} + 9'd1;
      end
      PH_DATA: begin
        held_data_nxt = item.data_byte;
        phase_nxt     = PH_SPCOUNT;
      end
      PH_SPCOUNT: begin
        emit_raw = 1'b1;
        value    = held_data_r;
        len_raw  = {1'b0, item.data_byte} + 9'd1;
      end
      PH_FULL: begin
        phase_nxt = PH_FULL;
      end
      default: begin
        phase_nxt = PH_ID;
      end
    endcase

    // Clamp the run to what is left of the frame.
    if ({6'b0, len_raw} > eff_left) begin
      len_clamped = eff_left[8:0];
    end else begin
      len_clamped = len_raw;
    end
    left_after     = eff_left - {6'b0, len_clamped};
    bytes_left_nxt = eff_left;
    if (emit_raw) begin
      bytes_left_nxt = left_after;
      phase_nxt      = (left_after == 15'd0) ? PH_FULL : PH_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_ID;
      id_code_r      <= 8'd0;
      pack_value_r   <= 8'd0;
      special_code_r <= 8'd0;
      held_data_r    <= 8'd0;
      bytes_left_r   <= FRAME_LEFT;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      id_code_r      <= id_code_nxt;
      pack_value_r   <= pack_value_nxt;
      special_code_r <= special_code_nxt;
      held_data_r    <= held_data_nxt;
      bytes_left_r   <= bytes_left_nxt;
    end
  end

  assign emit              = item_valid && emit_raw;
  assign result.run_value  = value;
  assign result.run_length = len_clamped;
  assign result.run_start  = FRAME_LEFT - eff_left;
  assign result.frame_done = (left_after == 15'd0);
endmodule
`default_nettype wire

// File: sv/escape_run_length_decoder.sv
// One byte per cycle while no held token stalls the output; a run token leaves on the byte that ends it.
// The input register feeds the phase machine, whose token lands in the output register.
// Reset (rst_n low, synchronous) empties both registers and re-arms for the id byte.
// After reset the frame counter holds FRAME_BYTES and the header codes read zero.
`default_nettype none
module escape_run_length_decoder #(
  parameter int unsigned FRAME_BYTES = 32000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_run_value,
  output logic [8:0]       out_run_length,
  output logic [14:0]      out_run_start,
  output logic             out_frame_done
);
  import erld_pkg::*;

  stage_t  in_item;
  stage_t  item;
  logic    item_valid;
  logic    in_load;
  logic    out_free;
  logic    dec_emit;
  logic    dec_fire;
  result_t dec_result;

  logic    out_valid_r, out_valid_nxt;
  result_t out_result_r;

  assign in_item.data_byte = in_data_byte;
  assign in_item.first     = in_first;

  // The output slot frees when it is empty or its token leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Advance the held byte unless its token has nowhere to go.
  assign dec_fire = item_valid && (!dec_emit || out_free);

  // Take a new byte whenever the input register empties or is empty.
  assign in_stall = item_valid && !dec_fire;
  assign in_load  = in_valid && !in_stall;

  erld_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .load       (in_load),
    .in_item    (in_item),
    .advance    (dec_fire),
    .item_valid (item_valid),
    .item       (item)
  );

  erld_decode #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (dec_fire),
    .emit       (dec_emit),
    .result     (dec_result)
  );

  // Output register: load a token when one is made, drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dec_fire && dec_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the token while the receiver stalls.
  always_ff @(posedge clk) begin
    if (dec_fire && dec_emit) begin
      out_result_r <= dec_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_value  = out_result_r.run_value;
  assign out_run_length = out_result_r.run_length;
  assign out_run_start  = out_result_r.run_start;
  assign out_frame_done = out_result_r.frame_done;
endmodule
`default_nettype wire

// File: sv/erld_checker.sv
// Port-level checker of the escape run-length decoder and its bind.
`default_nettype none
`include "escape_run_length_decoder_defines.svh"
module erld_checker #(
  parameter int unsigned FRAME_BYTES = 32000
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [8:0]  out_run_length,
  input wire logic [14:0] out_run_start,
  input wire logic        out_frame_done
);
  localparam logic [15:0] FRAME_END = 16'(FRAME_BYTES);

  logic [15:0] run_end;
  logic        len_ok;
  logic        at_end;
  assign run_end = {1'b0, out_run_start} + {7'b0, out_run_length};
  assign len_ok  = (out_run_length != 9'd0) && (out_run_length <= 9'd256);
  assign at_end  = (run_end == FRAME_END);

  `ERLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "token dropped while stalled")
  `ERLD_ASSERT_ALWAYS(a_len_range, !out_valid || len_ok, "run length out of range")
  `ERLD_ASSERT_ALWAYS(a_in_frame, !out_valid || run_end <= FRAME_END, "run passes the frame end")
  `ERLD_ASSERT_ALWAYS(a_done_end, !out_valid || (out_frame_done == at_end), "frame done flag wrong")
endmodule

bind escape_run_length_decoder erld_checker #(.FRAME_BYTES(FRAME_BYTES)) u_erld_checker (.*);
`default_nettype wire
